// File: hw/rtl/spi_master_byte_controller_macros.svh
// ---------------------------------------------------------------------------
// SPI master byte controller - assertion macros
// Shared property shorthands for the controller checks.
// ---------------------------------------------------------------------------
`ifndef SPI_MASTER_BYTE_CONTROLLER_MACROS_SVH
`define SPI_MASTER_BYTE_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define SMBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SMBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/smbc_pkg.sv
// ---------------------------------------------------------------------------
// smbc_pkg
// Codes and fixed field widths of the SPI master byte controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smbc_pkg;

    // Fixed field widths
    localparam int unsigned ACTION_W   = 2;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 16;

    // Input word kind
    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIVIDER  = 3'd0,
        CFG_CPOL     = 3'd1,
        CFG_CPHA     = 3'd2,
        CFG_CLK_EN   = 3'd3,
        CFG_IRQ_EN   = 3'd4
    } t_cfg_index;

endpackage

`default_nettype wire

// File: hw/rtl/spi_master_byte_controller.sv
// ---------------------------------------------------------------------------
// spi_master_byte_controller
// SPI master shifter, modes 0..3, prescaled serial clock, one word per tick.
// ---------------------------------------------------------------------------
// Channel    Dir  Handshake                    Payload
// s_axis     in   s_axis_tvalid/s_axis_tready  tuser: action; tdata: tx_byte, miso_bit
// m_axis     out  m_axis_tvalid/m_axis_tready  tdata: sclk, mosi, busy, ready, irq, rx_byte
// cfg        in   i_cfg_wr_en                  i_cfg_index, i_cfg_data
//
// One input word per clock while s_axis_tready is high; its result is registered
// in the output register, or in the skid register while one waits. State update
// for a word is a single pass of logic (prescaler compare, edge count, one shift).
// A two-entry output buffer keeps s_axis_tready high while one result waits on
// m_axis. Reset is synchronous, active low, and clears all control and shift state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "spi_master_byte_controller_macros.svh"

module spi_master_byte_controller #(
    parameter int unsigned DATA_BITS    = 8,
    parameter int unsigned DIVIDER_BITS = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // config write port
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [smbc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [smbc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input words
    input  wire logic                                s_axis_tvalid,
    output      logic                                s_axis_tready,
    input  wire logic [smbc_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [7:0] tx_byte, [8] miso_bit
    input  wire logic [smbc_pkg::ACTION_W-1:0]       s_axis_tuser,  // [1:0] action
    // result words
    output      logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output      logic [smbc_pkg::OUT_DATA_W-1:0]     m_axis_tdata   // [0] sclk_level, [1] mosi_bit,
                                                                    // [2] busy_res, [3] ready_res,
                                                                    // [4] irq_pulse, [12:5] rx_byte
);

    localparam int unsigned EC_W = $clog2(2 * DATA_BITS + 1);
    localparam int unsigned XW   = (DATA_BITS > smbc_pkg::BYTE_W) ? DATA_BITS : smbc_pkg::BYTE_W;
    localparam int unsigned DW   = (DIVIDER_BITS > smbc_pkg::CFG_DATA_W) ?
                                   DIVIDER_BITS : smbc_pkg::CFG_DATA_W;
    localparam logic [EC_W-1:0] LAST_EDGE = EC_W'(2 * DATA_BITS);
    localparam logic [EC_W-1:0] ONE_EDGE  = EC_W'(1);

    // config registers
    logic [DIVIDER_BITS-1:0] r_div;
    logic                    r_cpol;
    logic                    r_cpha;
    logic                    r_clk_en;
    logic                    r_irq_en;

    // shifter state
    logic [DATA_BITS-1:0]    r_shift, n_shift;
    logic [DATA_BITS-1:0]    r_rx, n_rx;
    logic [DIVIDER_BITS-1:0] r_pc, n_pc;
    logic [EC_W-1:0]         r_ec, n_ec;
    logic                    r_sclk, n_sclk;
    logic                    r_busy, n_busy;
    logic                    r_ready, n_ready;
    logic                    r_sampled, n_sampled;

    // output buffer
    logic                                r_out_valid;
    logic [smbc_pkg::OUT_DATA_W-1:0]     r_out_data;
    logic                                r_skid_valid;
    logic [smbc_pkg::OUT_DATA_W-1:0]     r_skid_data;

    logic                                accept;
    logic                                pop;
    smbc_pkg::t_action                   act;
    logic [smbc_pkg::BYTE_W-1:0]         tx_byte;
    logic                                miso;
    logic                                irq;
    logic [smbc_pkg::BYTE_W-1:0]         rx_out;
    logic [XW-1:0]                       tx_ext;
    logic [XW-1:0]                       rx_ext;
    logic [DW-1:0]                       div_ext;
    logic                                cfg_cpol;
    logic [smbc_pkg::OUT_DATA_W-1:0]     n_word;

    // Input fields
    assign act     = smbc_pkg::t_action'(s_axis_tuser);
    assign tx_byte = s_axis_tdata[smbc_pkg::BYTE_W-1:0];
    assign miso    = s_axis_tdata[smbc_pkg::BYTE_W];
    assign tx_ext  = XW'(tx_byte);
    assign rx_ext  = XW'(r_rx);
    assign div_ext = DW'(i_cfg_data);

    // Handshake
    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = r_out_valid && m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Polarity as it stands after a config write this cycle
    assign cfg_cpol = (i_cfg_wr_en && i_cfg_index == smbc_pkg::CFG_CPOL) ? i_cfg_data[0] : r_cpol;

    // Next shifter state for one input word
    always_comb begin
        n_shift   = r_shift;
        n_rx      = r_rx;
        n_pc      = r_pc;
        n_ec      = r_ec;
        n_sclk    = r_sclk;
        n_busy    = r_busy;
        n_ready   = r_ready;
        n_sampled = r_sampled;
        irq       = 1'b0;
        rx_out    = '0;
        unique case (act)
            smbc_pkg::ACT_TICK: begin
                if (r_busy && r_clk_en) begin
                    if (r_pc < r_div) begin
                        n_pc = r_pc + DIVIDER_BITS'(1);
                    end else begin
                        // serial clock edge
                        n_pc   = '0;
                        n_sclk = ~r_sclk;
                        n_ec   = r_ec + ONE_EDGE;
                        if (!r_cpha) begin
                            if (n_ec[0]) begin
                                n_sampled = miso;
                            end else begin
                                n_shift = {r_shift[DATA_BITS-2:0], r_sampled};
                            end
                        end else begin
                            if (!n_ec[0]) begin
                                n_sampled = miso;
                            end else if (n_ec > ONE_EDGE) begin
                                n_shift = {r_shift[DATA_BITS-2:0], r_sampled};
                            end
                        end
                        // last edge: latch the word
                        if (n_ec >= LAST_EDGE) begin
                            if (r_cpha) begin
                                n_shift = {n_shift[DATA_BITS-2:0], n_sampled};
                            end
                            n_rx    = n_shift;
                            n_ready = 1'b1;
                            n_busy  = 1'b0;
                            n_ec    = '0;
                            irq     = r_irq_en;
                        end
                    end
                end
            end
            smbc_pkg::ACT_WRITE: begin
                if (!r_busy) begin
                    n_shift   = tx_ext[DATA_BITS-1:0];
                    n_busy    = 1'b1;
                    n_ec      = '0;
                    n_pc      = '0;
                    n_sampled = 1'b0;
                    n_sclk    = r_cpol;
                end
            end
            smbc_pkg::ACT_READ: begin
                rx_out  = rx_ext[smbc_pkg::BYTE_W-1:0];
                n_ready = 1'b0;
            end
            default: begin
            end
        endcase
        // idle clock follows polarity
        if (!n_busy) begin
            n_sclk = r_cpol;
        end
    end

    // Result word
    assign n_word = smbc_pkg::OUT_DATA_W'({rx_out, irq, n_ready, n_busy,
                                           n_shift[DATA_BITS-1], n_sclk});

    // Shifter state and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div     <= '0;
            r_cpol    <= 1'b0;
            r_cpha    <= 1'b0;
            r_clk_en  <= 1'b0;
            r_irq_en  <= 1'b0;
            r_shift   <= '0;
            r_rx      <= '0;
            r_pc      <= '0;
            r_ec      <= '0;
            r_sclk    <= 1'b0;
            r_busy    <= 1'b0;
            r_ready   <= 1'b0;
            r_sampled <= 1'b0;
        end else begin
            if (accept) begin
                r_shift   <= n_shift;
                r_rx      <= n_rx;
                r_pc      <= n_pc;
                r_ec      <= n_ec;
                r_busy    <= n_busy;
                r_ready   <= n_ready;
                r_sampled <= n_sampled;
            end
            // idle clock tracks a config write, else the word's clock level
            if (i_cfg_wr_en && !r_busy) begin
                r_sclk <= cfg_cpol;
            end else if (accept) begin
                r_sclk <= n_sclk;
            end
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    smbc_pkg::CFG_DIVIDER: r_div    <= div_ext[DIVIDER_BITS-1:0];
                    smbc_pkg::CFG_CPOL:    r_cpol   <= i_cfg_data[0];
                    smbc_pkg::CFG_CPHA:    r_cpha   <= i_cfg_data[0];
                    smbc_pkg::CFG_CLK_EN:  r_clk_en <= i_cfg_data[0];
                    smbc_pkg::CFG_IRQ_EN:  r_irq_en <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else if (accept) begin
            if (!r_out_valid || pop) begin
                r_out_data  <= n_word;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_data  <= n_word;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Checks
    `SMBC_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n,
                     r_skid_valid, r_out_valid, "skid word without output word")
    `SMBC_ASSERT_NOW(a_idle_edges_clear, i_clk, i_rst_n,
                     !r_busy, r_ec == '0, "edge count nonzero while idle")
    `SMBC_ASSERT_NOW(a_idle_clock_level, i_clk, i_rst_n,
                     !r_busy, r_sclk == r_cpol, "idle clock not at polarity")
    `SMBC_ASSERT_NEXT(a_write_starts, i_clk, i_rst_n,
                      accept && act == smbc_pkg::ACT_WRITE && !r_busy, r_busy,
                      "write did not start transfer")

endmodule

`default_nettype wire
